@@ rtl/core/sfq_pkg.sv @@
`timescale 1ns / 1ps
package sfq_pkg;

    localparam int HEAP_CAPACITY = 64;
    localparam int IDX_W         = $clog2(HEAP_CAPACITY);
    localparam int CNT_W         = IDX_W + 1;
    localparam int TAG_BITS      = 31;
    localparam int ID_BITS       = 16;
    localparam int LEN_W         = 16;
    localparam int DLIM_W        = 7;
    localparam int OUTST_W       = 7;

    localparam logic [OUTST_W-1:0] OUTST_MAX = {OUTST_W{1'b1}};
    localparam logic [LEN_W-1:0]   LEN_RESET = LEN_W'(100);
    localparam logic [DLIM_W-1:0]  DLIM_RESET = DLIM_W'(1);

    typedef logic [1:0] t_op;
    localparam t_op OP_ARRIVE   = 2'd0;
    localparam t_op OP_DISPATCH = 2'd1;
    localparam t_op OP_COMPLETE = 2'd2;

    typedef logic [1:0] t_status;
    localparam t_status ST_OK   = 2'd0;
    localparam t_status ST_FULL = 2'd1;
    localparam t_status ST_OVF  = 2'd2;
    localparam t_status ST_NONE = 2'd3;

    localparam logic REG_LENGTH = 1'b0;
    localparam logic REG_DEPTH  = 1'b1;

    typedef struct packed {
        logic [TAG_BITS-1:0] start;
        logic [TAG_BITS-1:0] finish;
        logic [ID_BITS-1:0]  id;
    } t_entry;

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_FIN_FULL,
        CMD_FIN_OVF,
        CMD_FIN_NONE,
        CMD_FIN_COMPLETE,
        CMD_ARR_START,
        CMD_ARR_TAG,
        CMD_ARR_COMMIT,
        CMD_UP_READ,
        CMD_UP_CMP,
        CMD_UP_PLACE,
        CMD_DSP_RD_ROOT,
        CMD_DSP_CAP_ROOT,
        CMD_DSP_CAP_LAST,
        CMD_DN_RD_L,
        CMD_DN_RD_R,
        CMD_DN_CMP,
        CMD_DN_MOVE,
        CMD_DN_PLACE
    } t_cmd;

    typedef struct packed {
        logic heap_full;
        logic can_dispatch;
        logic overflow;
        logic idx_zero;
        logic up_less;
        logic lc_valid;
        logic child;
    } t_dp_status;

endpackage

@@ rtl/core/sfq_ram.sv @@
`timescale 1ns / 1ps
module sfq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/sfq_ctrl.sv @@
`timescale 1ns / 1ps
module sfq_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  sfq_pkg::t_op        i_opcode,
    input  sfq_pkg::t_dp_status i_status,
    output sfq_pkg::t_cmd       o_cmd,
    output logic                o_busy
);
    import sfq_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ARR_TAG,
        S_ARR_CHK,
        S_UP_RD,
        S_UP_CMP,
        S_DSP_ROOT,
        S_DSP_LAST,
        S_DN_RL,
        S_DN_RR,
        S_DN_CMP,
        S_DN_MV
    } t_state;

    t_state r_state;
    t_state n_state;
    t_cmd   cmd;

    always_comb begin
        n_state = r_state;
        cmd     = CMD_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    case (i_opcode)
                        OP_ARRIVE: begin
                            if (i_status.heap_full) begin
                                cmd = CMD_FIN_FULL;
                            end else begin
                                cmd     = CMD_ARR_START;
                                n_state = S_ARR_TAG;
                            end
                        end
                        OP_DISPATCH: begin
                            if (i_status.can_dispatch) begin
                                cmd     = CMD_DSP_RD_ROOT;
                                n_state = S_DSP_ROOT;
                            end else begin
                                cmd = CMD_FIN_NONE;
                            end
                        end
                        OP_COMPLETE: cmd = CMD_FIN_COMPLETE;
                        default:     cmd = CMD_FIN_NONE;
                    endcase
                end
            end
            S_ARR_TAG: begin
                cmd     = CMD_ARR_TAG;
                n_state = S_ARR_CHK;
            end
            S_ARR_CHK: begin
                if (i_status.overflow) begin
                    cmd     = CMD_FIN_OVF;
                    n_state = S_IDLE;
                end else begin
                    cmd     = CMD_ARR_COMMIT;
                    n_state = S_UP_RD;
                end
            end
            S_UP_RD: begin
                if (i_status.idx_zero) begin
                    cmd     = CMD_UP_PLACE;
                    n_state = S_IDLE;
                end else begin
                    cmd     = CMD_UP_READ;
                    n_state = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                cmd     = CMD_UP_CMP;
                n_state = i_status.up_less ? S_UP_RD : S_IDLE;
            end
            S_DSP_ROOT: begin
                cmd     = CMD_DSP_CAP_ROOT;
                n_state = S_DSP_LAST;
            end
            S_DSP_LAST: begin
                cmd     = CMD_DSP_CAP_LAST;
                n_state = S_DN_RL;
            end
            S_DN_RL: begin
                if (i_status.lc_valid) begin
                    cmd     = CMD_DN_RD_L;
                    n_state = S_DN_RR;
                end else begin
                    cmd     = CMD_DN_PLACE;
                    n_state = S_IDLE;
                end
            end
            S_DN_RR: begin
                cmd     = CMD_DN_RD_R;
                n_state = S_DN_CMP;
            end
            S_DN_CMP: begin
                cmd     = CMD_DN_CMP;
                n_state = S_DN_MV;
            end
            S_DN_MV: begin
                if (i_status.child) begin
                    cmd     = CMD_DN_MOVE;
                    n_state = S_DN_RL;
                end else begin
                    cmd     = CMD_DN_PLACE;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd  = cmd;
    assign o_busy = (r_state != S_IDLE);

endmodule

@@ rtl/core/sfq_dpath.sv @@
`timescale 1ns / 1ps
module sfq_dpath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  sfq_pkg::t_cmd                  i_cmd,
    input  logic [sfq_pkg::ID_BITS-1:0]    i_request_id,
    input  logic [sfq_pkg::LEN_W-1:0]      i_request_length,
    input  logic [sfq_pkg::DLIM_W-1:0]     i_depth_limit,
    output sfq_pkg::t_dp_status            o_status,
    output logic                           o_result_valid,
    output sfq_pkg::t_status               o_res_status,
    output logic                           o_dispatched,
    output logic [sfq_pkg::ID_BITS-1:0]    o_out_request_id,
    output logic [sfq_pkg::TAG_BITS-1:0]   o_out_start_tag,
    output logic [sfq_pkg::TAG_BITS-1:0]   o_out_finish_tag,
    output logic [sfq_pkg::CNT_W-1:0]      o_queued_count,
    output logic [sfq_pkg::OUTST_W-1:0]    o_outstanding,
    output logic                           o_kick
);
    import sfq_pkg::*;

    logic [TAG_BITS-1:0] r_vc;
    logic [CNT_W-1:0]    r_count;
    logic [OUTST_W-1:0]  r_outst;
    t_entry              r_new;
    t_entry              r_best;
    logic [IDX_W-1:0]    r_idx;
    logic [IDX_W-1:0]    r_best_idx;
    logic                r_child;
    logic                r_ovf;

    logic                r_strobe;
    t_status             r_status;
    logic                r_disp;
    logic [ID_BITS-1:0]  r_oid;
    logic [TAG_BITS-1:0] r_ost;
    logic [TAG_BITS-1:0] r_ofin;
    logic                r_kick;

    logic [IDX_W-1:0]    ram_addr;
    logic                ram_we;
    t_entry              ram_wdata;
    t_entry              rdata;

    logic [IDX_W-1:0]    parent;
    logic [IDX_W-1:0]    last_idx;
    logic [CNT_W:0]      lc_w;
    logic [CNT_W:0]      rc_w;
    logic                lc_valid;
    logic                rc_valid;
    logic                up_less;
    logic [TAG_BITS-1:0] vc_next;
    logic [TAG_BITS:0]   fin_sum;
    logic [TAG_BITS-1:0] best_start;

    assign parent     = (r_idx - IDX_W'(1)) >> 1;
    assign last_idx   = r_count[IDX_W-1:0] - IDX_W'(1);
    assign lc_w       = {1'b0, r_idx, 1'b1};
    assign rc_w       = lc_w + (CNT_W+1)'(1);
    assign lc_valid   = lc_w < {1'b0, r_count};
    assign rc_valid   = rc_w < {1'b0, r_count};
    assign up_less    = r_new.start < rdata.start;
    assign best_start = r_child ? r_best.start : r_new.start;

    // virtual time catches up with the finish tag in the last slot
    assign vc_next = (r_count != '0 && r_vc < rdata.finish) ? rdata.finish : r_vc;
    assign fin_sum = {1'b0, vc_next} + (TAG_BITS+1)'(i_request_length);

    always_comb begin
        ram_addr  = r_idx;
        ram_we    = 1'b0;
        ram_wdata = r_new;
        case (i_cmd)
            CMD_ARR_START:    ram_addr = last_idx;
            CMD_UP_READ:      ram_addr = parent;
            CMD_UP_CMP: begin
                ram_we    = 1'b1;
                ram_wdata = up_less ? rdata : r_new;
            end
            CMD_UP_PLACE:     ram_we = 1'b1;
            CMD_DSP_RD_ROOT:  ram_addr = '0;
            CMD_DSP_CAP_ROOT: ram_addr = r_count[IDX_W-1:0];
            CMD_DN_RD_L:      ram_addr = lc_w[IDX_W-1:0];
            CMD_DN_RD_R:      ram_addr = rc_w[IDX_W-1:0];
            CMD_DN_MOVE: begin
                ram_we    = 1'b1;
                ram_wdata = r_best;
            end
            CMD_DN_PLACE:     ram_we = 1'b1;
            default:          ram_we = 1'b0;
        endcase
    end

    sfq_ram #(
        .WIDTH($bits(t_entry)),
        .DEPTH(HEAP_CAPACITY)
    ) u_heap (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc     <= '0;
            r_count  <= '0;
            r_outst  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            case (i_cmd)
                CMD_FIN_FULL, CMD_FIN_OVF, CMD_FIN_NONE: begin
                    r_strobe <= 1'b1;
                    r_status <= (i_cmd == CMD_FIN_FULL) ? ST_FULL :
                                (i_cmd == CMD_FIN_OVF)  ? ST_OVF  : ST_NONE;
                    r_disp   <= 1'b0;
                    r_oid    <= '0;
                    r_ost    <= '0;
                    r_ofin   <= '0;
                    r_kick   <= 1'b0;
                end
                CMD_FIN_COMPLETE: begin
                    r_strobe <= 1'b1;
                    r_status <= ST_OK;
                    r_disp   <= 1'b0;
                    r_oid    <= '0;
                    r_ost    <= '0;
                    r_ofin   <= '0;
                    r_kick   <= r_outst > OUTST_W'(1);
                    if (r_outst != '0) begin
                        r_outst <= r_outst - OUTST_W'(1);
                    end
                end
                CMD_ARR_START: begin
                    r_new.id <= i_request_id;
                    r_idx    <= r_count[IDX_W-1:0];
                end
                CMD_ARR_TAG: begin
                    r_vc         <= vc_next;
                    r_new.start  <= vc_next;
                    r_new.finish <= fin_sum[TAG_BITS-1:0];
                    r_ovf        <= fin_sum[TAG_BITS];
                end
                CMD_ARR_COMMIT: r_count <= r_count + CNT_W'(1);
                CMD_UP_CMP, CMD_UP_PLACE: begin
                    if (i_cmd == CMD_UP_CMP && up_less) begin
                        r_idx <= parent;
                    end else begin
                        r_strobe <= 1'b1;
                        r_status <= ST_OK;
                        r_disp   <= 1'b0;
                        r_oid    <= '0;
                        r_ost    <= r_new.start;
                        r_ofin   <= r_new.finish;
                        r_kick   <= 1'b0;
                    end
                end
                CMD_DSP_RD_ROOT: begin
                    r_count <= r_count - CNT_W'(1);
                    r_outst <= r_outst + OUTST_W'(1);
                    r_idx   <= '0;
                end
                CMD_DSP_CAP_ROOT: begin
                    r_oid  <= rdata.id;
                    r_ost  <= rdata.start;
                    r_ofin <= rdata.finish;
                end
                CMD_DSP_CAP_LAST: r_new <= rdata;
                CMD_DN_RD_R: begin
                    // left child wins only when strictly below the node
                    r_best     <= rdata;
                    r_best_idx <= lc_w[IDX_W-1:0];
                    r_child    <= rdata.start < r_new.start;
                end
                CMD_DN_CMP: begin
                    if (rc_valid && rdata.start < best_start) begin
                        r_best     <= rdata;
                        r_best_idx <= rc_w[IDX_W-1:0];
                        r_child    <= 1'b1;
                    end
                end
                CMD_DN_MOVE: r_idx <= r_best_idx;
                CMD_DN_PLACE: begin
                    r_strobe <= 1'b1;
                    r_status <= ST_OK;
                    r_disp   <= 1'b1;
                    r_kick   <= 1'b0;
                end
                default: r_strobe <= 1'b0;
            endcase
        end
    end

    assign o_status.heap_full    = (r_count == CNT_W'(HEAP_CAPACITY));
    assign o_status.can_dispatch = (r_count != '0) &&
                                   (r_outst <= i_depth_limit) &&
                                   (r_outst != OUTST_MAX);
    assign o_status.overflow     = r_ovf;
    assign o_status.idx_zero     = (r_idx == '0);
    assign o_status.up_less      = up_less;
    assign o_status.lc_valid     = lc_valid;
    assign o_status.child        = r_child;

    assign o_result_valid   = r_strobe;
    assign o_res_status     = r_status;
    assign o_dispatched     = r_disp;
    assign o_out_request_id = r_oid;
    assign o_out_start_tag  = r_ost;
    assign o_out_finish_tag = r_ofin;
    assign o_queued_count   = r_count;
    assign o_outstanding    = r_outst;
    assign o_kick           = r_kick;

endmodule

@@ rtl/core/sfq_heap_request_scheduler_unit.sv @@
`timescale 1ns / 1ps
// Start-time fair queuing scheduler over a 64-entry binary min-heap held in one
// single-port RAM. An item is taken when start is high and busy low; its result
// appears for one cycle on the o_ ports with o_result_valid and must be taken
// then. Full-heap refusals, refused dispatches, completions and opcode 3 answer
// the cycle after start and leave busy low; a tag overflow is refused once the
// tags are computed, before the entry is committed. An arrival reads the last
// slot, computes its tags, commits and then climbs the heap level by level; a
// dispatch reads the root and the last slot, then sifts down level by level.
// Busy stays high through the heap walk, one RAM read-compare-write per level.
module sfq_heap_request_scheduler_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [1:0]                      i_opcode,
    input  logic [sfq_pkg::ID_BITS-1:0]     i_request_id,
    output logic                            o_result_valid,
    output logic [1:0]                      o_status,
    output logic                            o_dispatched,
    output logic [sfq_pkg::ID_BITS-1:0]     o_out_request_id,
    output logic [sfq_pkg::TAG_BITS-1:0]    o_out_start_tag,
    output logic [sfq_pkg::TAG_BITS-1:0]    o_out_finish_tag,
    output logic [sfq_pkg::CNT_W-1:0]       o_queued_count,
    output logic [sfq_pkg::OUTST_W-1:0]     o_outstanding,
    output logic                            o_kick,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [2:0]                      paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import sfq_pkg::*;

    logic [LEN_W-1:0]  r_request_length;
    logic [DLIM_W-1:0] r_depth_limit;
    t_cmd              cmd;
    t_dp_status        dp_status;
    logic              cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_request_length <= LEN_RESET;
            r_depth_limit    <= DLIM_RESET;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_LENGTH: r_request_length <= pwdata[LEN_W-1:0];
                REG_DEPTH:  r_depth_limit    <= pwdata[DLIM_W-1:0];
                default:    r_depth_limit    <= r_depth_limit;
            endcase
        end
    end

    assign prdata = (paddr[2] == REG_DEPTH) ? {{(32-DLIM_W){1'b0}}, r_depth_limit}
                                            : {{(32-LEN_W){1'b0}}, r_request_length};

    sfq_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_opcode (i_opcode),
        .i_status (dp_status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    sfq_dpath u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_request_id     (i_request_id),
        .i_request_length (r_request_length),
        .i_depth_limit    (r_depth_limit),
        .o_status         (dp_status),
        .o_result_valid   (o_result_valid),
        .o_res_status     (o_status),
        .o_dispatched     (o_dispatched),
        .o_out_request_id (o_out_request_id),
        .o_out_start_tag  (o_out_start_tag),
        .o_out_finish_tag (o_out_finish_tag),
        .o_queued_count   (o_queued_count),
        .o_outstanding    (o_outstanding),
        .o_kick           (o_kick)
    );

endmodule
